[rtl/spte_pkg.sv]
// Shared types and codes for the sparse polynomial term engine.
// No dependencies; used by every module of the block.
`default_nettype none
package spte_pkg;

    localparam int CAP_DEF = 32;
    localparam int CNT_W   = 7;
    localparam int COEF_W  = 64;
    localparam int EXP_W   = 16;
    localparam int ACT_W   = 4;
    localparam int ST_W    = 2;
    localparam int OP_W    = 3;
    localparam int MUL_LAT = 2;

    localparam logic [ACT_W-1:0] ACT_CLR_A = 4'd0;
    localparam logic [ACT_W-1:0] ACT_CLR_B = 4'd1;
    localparam logic [ACT_W-1:0] ACT_ATT_A = 4'd2;
    localparam logic [ACT_W-1:0] ACT_ATT_B = 4'd3;
    localparam logic [ACT_W-1:0] ACT_REM   = 4'd4;
    localparam logic [ACT_W-1:0] ACT_SCALE = 4'd5;
    localparam logic [ACT_W-1:0] ACT_ADD   = 4'd6;
    localparam logic [ACT_W-1:0] ACT_MUL   = 4'd7;
    localparam logic [ACT_W-1:0] ACT_READ  = 4'd8;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd3;

    // cell operations
    localparam logic [OP_W-1:0] OP_HOLD = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS  = 3'd2;
    localparam logic [OP_W-1:0] OP_ROT  = 3'd3;
    localparam logic [OP_W-1:0] OP_APP  = 3'd4;
    localparam logic [OP_W-1:0] OP_COPY = 3'd5;

    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic [EXP_W-1:0]  expon;
    } t_term;

    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [COEF_W-1:0] coef;
        logic [EXP_W-1:0]  expon;
    } t_cell_ctl;

endpackage
`default_nettype wire

[rtl/spte_cell.sv]
// One term cell of a table chain: holds a term, compares, adds, shifts, inserts, appends, copies.
// Depends on spte_pkg.
`default_nettype none
module spte_cell (
    input  wire logic                        i_clk,
    input  wire logic [spte_pkg::OP_W-1:0]   i_op,
    input  wire spte_pkg::t_cell_ctl         i_ctl,
    input  wire logic [spte_pkg::CNT_W-1:0]  i_idx,
    input  wire spte_pkg::t_term             i_left,
    input  wire logic                        i_left_gt,
    input  wire spte_pkg::t_term             i_right,
    input  wire spte_pkg::t_term             i_head,
    input  wire spte_pkg::t_term             i_copy,
    output spte_pkg::t_term                  o_term,
    output logic                             o_gt,
    output logic                             o_match
);
    spte_pkg::t_term r_term, n_term, w_new;
    logic            w_live;
    logic [spte_pkg::CNT_W-1:0] w_nxt;

    always_comb begin
        w_live  = i_idx < i_ctl.cnt;
        o_gt    = w_live && (r_term.expon > i_ctl.expon);
        o_match = w_live && (r_term.expon == i_ctl.expon);
        w_new.coef  = i_ctl.coef;
        w_new.expon = i_ctl.expon;
        w_nxt   = i_idx + 1'b1;
        n_term  = r_term;
        case (i_op)
            spte_pkg::OP_ADD: begin
                if (o_match) n_term.coef = r_term.coef + i_ctl.coef;
            end
            spte_pkg::OP_INS: begin
                if (i_idx <= i_ctl.cnt && !o_gt)
                    n_term = (i_idx == '0 || i_left_gt) ? w_new : i_left;
            end
            spte_pkg::OP_ROT: begin
                if (w_nxt < i_ctl.cnt) n_term = i_right;
                else if (w_nxt == i_ctl.cnt) n_term = i_head;
            end
            spte_pkg::OP_APP: begin
                if (i_idx == i_ctl.cnt) n_term = w_new;
            end
            spte_pkg::OP_COPY: n_term = i_copy;
            default: n_term = r_term;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_term <= n_term;
    end

    assign o_term = r_term;
endmodule
`default_nettype wire

[rtl/spte_row.sv]
// A chain of term cells forming one sorted table.
// Depends on spte_pkg and spte_cell.
`default_nettype none
module spte_row #(
    parameter int CAPACITY = spte_pkg::CAP_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic [spte_pkg::OP_W-1:0]  i_op,
    input  wire spte_pkg::t_cell_ctl        i_ctl,
    input  wire spte_pkg::t_term            i_copy [CAPACITY],
    output spte_pkg::t_term                 o_terms [CAPACITY],
    output logic                            o_match_any
);
    logic [CAPACITY-1:0] w_gt, w_match;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        spte_cell u_cell (
            .i_clk    (i_clk),
            .i_op     (i_op),
            .i_ctl    (i_ctl),
            .i_idx    (spte_pkg::CNT_W'(k)),
            .i_left   ((k == 0) ? o_terms[0] : o_terms[(k == 0) ? 0 : k-1]),
            .i_left_gt((k == 0) ? 1'b0 : w_gt[(k == 0) ? 0 : k-1]),
            .i_right  (o_terms[(k == CAPACITY-1) ? k : k+1]),
            .i_head   (o_terms[0]),
            .i_copy   (i_copy[k]),
            .o_term   (o_terms[k]),
            .o_gt     (w_gt[k]),
            .o_match  (w_match[k])
        );
    end

    assign o_match_any = |w_match;
endmodule
`default_nettype wire

[rtl/spte_mul.sv]
// Two-stage 64x64 multiplier keeping the low 64 bits, exponent tag carried along.
// Depends on spte_pkg.
`default_nettype none
module spte_mul (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic [spte_pkg::COEF_W-1:0]  i_a,
    input  wire logic [spte_pkg::COEF_W-1:0]  i_b,
    input  wire logic [spte_pkg::EXP_W-1:0]   i_expon,
    output logic                              o_valid,
    output logic [spte_pkg::COEF_W-1:0]       o_prod,
    output logic [spte_pkg::EXP_W-1:0]        o_expon
);
    logic [63:0] r_p0;
    logic [31:0] r_p1, r_p2, w_p1, w_p2;
    logic [63:0] w_p0;
    logic [31:0] w_cross;
    logic        r_v1, r_v2;
    logic [spte_pkg::EXP_W-1:0] r_e1, r_e2;
    logic [63:0] r_prod;

    always_comb begin
        w_p0    = {32'd0, i_a[31:0]} * {32'd0, i_b[31:0]};
        w_p1    = i_a[63:32] * i_b[31:0];
        w_p2    = i_a[31:0] * i_b[63:32];
        w_cross = r_p1 + r_p2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_p0   <= w_p0;
        r_p1   <= w_p1;
        r_p2   <= w_p2;
        r_e1   <= i_expon;
        r_prod <= r_p0 + {w_cross, 32'd0};
        r_e2   <= r_e1;
    end

    assign o_valid = r_v2;
    assign o_prod  = r_prod;
    assign o_expon = r_e2;
endmodule
`default_nettype wire

[rtl/sparse_polynomial_term_engine.sv]
// Top level: sequencer over three term chains (A, B, work) and a shared multiplier.
// Depends on spte_pkg, spte_row, spte_cell and spte_mul.
//
//  channel  dir  tdata                                   tuser         tlast
//  s        in   coef[31:0] expon[47:32]                  action[3:0]   -
//  m        out  term_coef[63:0] term_expon[79:64]        status[1:0]   last
//                term_count[85:80] lead_expon[101:86]
//
// Clear, attach and unknown actions go straight from execute to output. Scale and remove
// stream A, add merges A and B into at most count(A)+count(B) terms, multiply streams every
// pair of A and B: each chain offers one term per cycle at its head and the multiplier takes
// one pair per cycle. Read sends one word per term of A, one per cycle while the output is not
// stalled. Reset is synchronous, active low, and clears control only.
// A stalled output holds the sequencer in place.
`default_nettype none
module sparse_polynomial_term_engine #(
    parameter int CAPACITY = spte_pkg::CAP_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [47:0]  i_s_tdata,   // coef, expon
    input  wire logic [3:0]   i_s_tuser,   // action
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [103:0]      o_m_tdata,   // term_coef, term_expon, term_count, lead_expon
    output logic [1:0]        o_m_tuser,   // status
    output logic              o_m_tlast
);
    localparam int CW = spte_pkg::CNT_W;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_STREAM = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;
    localparam logic [2:0] S_READ   = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [3:0]  r_act;
    logic [63:0] r_coef;
    logic [15:0] r_expon, r_lead, n_lead;
    logic [CW-1:0] r_acnt, n_acnt, r_bcnt, n_bcnt, r_n, n_n, r_i, n_i, r_j, n_j;
    logic        r_ovf, n_ovf, r_found, n_found;
    logic [1:0]  r_drain, n_drain;
    logic [1:0]  r_st, n_st;

    logic        r_mvalid, n_mvalid, r_mlast, n_mlast;
    logic [1:0]  r_mst, n_mst;
    logic [63:0] r_mcoef, n_mcoef;
    logic [15:0] r_mexp, n_mexp, r_mlead, n_mlead;
    logic [5:0]  r_mcnt, n_mcnt;

    logic [spte_pkg::OP_W-1:0] a_op, b_op, w_op;
    spte_pkg::t_cell_ctl a_ctl, b_ctl, w_ctl;
    spte_pkg::t_term a_terms [CAPACITY];
    spte_pkg::t_term b_terms [CAPACITY];
    spte_pkg::t_term w_terms [CAPACITY];
    logic a_match, b_match, w_match;

    logic        mul_iv, mul_ov;
    logic [63:0] mul_b, mul_prod;
    logic [15:0] mul_ie, mul_oe;

    logic        out_free, a_av, b_av, take_a, take_b, done_strm;
    logic [16:0] esum;
    logic [63:0] w_coef;
    logic [15:0] w_exp, a_lead;

    spte_row #(.CAPACITY(CAPACITY)) u_row_a (
        .i_clk(i_clk), .i_op(a_op), .i_ctl(a_ctl), .i_copy(w_terms),
        .o_terms(a_terms), .o_match_any(a_match)
    );
    spte_row #(.CAPACITY(CAPACITY)) u_row_b (
        .i_clk(i_clk), .i_op(b_op), .i_ctl(b_ctl), .i_copy(w_terms),
        .o_terms(b_terms), .o_match_any(b_match)
    );
    spte_row #(.CAPACITY(CAPACITY)) u_row_w (
        .i_clk(i_clk), .i_op(w_op), .i_ctl(w_ctl), .i_copy(a_terms),
        .o_terms(w_terms), .o_match_any(w_match)
    );

    spte_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(mul_iv),
        .i_a(a_terms[0].coef), .i_b(mul_b), .i_expon(mul_ie),
        .o_valid(mul_ov), .o_prod(mul_prod), .o_expon(mul_oe)
    );

    always_comb begin
        out_free = !r_mvalid || i_m_tready;
        a_av     = r_i < r_acnt;
        b_av     = r_j < r_bcnt;
        take_a   = a_av && (!b_av || a_terms[0].expon > b_terms[0].expon);
        take_b   = b_av && (!a_av || a_terms[0].expon < b_terms[0].expon);
        esum     = {1'b0, a_terms[0].expon} + {1'b0, b_terms[0].expon};
        a_lead   = (r_acnt != '0) ? a_terms[0].expon : 16'd0;
        case (r_act)
            spte_pkg::ACT_SCALE: done_strm = (r_i == r_acnt);
            spte_pkg::ACT_REM:   done_strm = (r_i == r_acnt);
            spte_pkg::ACT_ADD:   done_strm = !a_av && !b_av;
            default:             done_strm = (r_acnt == '0) || (r_bcnt == '0)
                                             || (r_i == r_acnt);
        endcase
    end

    always_comb begin
        n_state = r_state; n_acnt = r_acnt; n_bcnt = r_bcnt; n_n = r_n;
        n_i = r_i; n_j = r_j; n_ovf = r_ovf; n_found = r_found;
        n_drain = r_drain; n_st = r_st; n_lead = r_lead;
        n_mvalid = r_mvalid && !i_m_tready;
        n_mlast = r_mlast; n_mst = r_mst; n_mcoef = r_mcoef; n_mexp = r_mexp;
        n_mlead = r_mlead; n_mcnt = r_mcnt;
        a_op = spte_pkg::OP_HOLD; b_op = spte_pkg::OP_HOLD; w_op = spte_pkg::OP_HOLD;
        a_ctl = '{cnt: r_acnt, coef: r_coef, expon: r_expon};
        b_ctl = '{cnt: r_bcnt, coef: r_coef, expon: r_expon};
        w_coef = a_terms[0].coef;
        w_exp  = a_terms[0].expon;
        mul_iv = 1'b0;
        mul_b  = r_coef;
        mul_ie = a_terms[0].expon;

        // products returning from the multiplier
        if (r_act == spte_pkg::ACT_MUL || r_act == spte_pkg::ACT_SCALE) begin
            w_coef = mul_prod;
            w_exp  = mul_oe;
        end
        if (mul_ov && r_act == spte_pkg::ACT_SCALE) begin
            w_op = spte_pkg::OP_APP;
            n_n  = r_n + 1'b1;
        end else if (mul_ov && r_act == spte_pkg::ACT_MUL && !r_ovf) begin
            if (w_match) begin
                w_op = spte_pkg::OP_ADD;
            end else if (r_n < CAP) begin
                w_op = spte_pkg::OP_INS;
                n_n  = r_n + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_EXEC;
                n_n = '0; n_i = '0; n_j = '0; n_ovf = 1'b0; n_found = 1'b0;
                n_st = spte_pkg::ST_OK;
            end
            S_EXEC: begin
                n_state = S_OUT;
                case (r_act)
                    spte_pkg::ACT_CLR_A: n_acnt = '0;
                    spte_pkg::ACT_CLR_B: n_bcnt = '0;
                    spte_pkg::ACT_ATT_A: begin
                        if (a_match) a_op = spte_pkg::OP_ADD;
                        else if (r_acnt < CAP) begin
                            a_op = spte_pkg::OP_INS;
                            n_acnt = r_acnt + 1'b1;
                        end else n_st = spte_pkg::ST_OVERFLOW;
                    end
                    spte_pkg::ACT_ATT_B: begin
                        if (b_match) b_op = spte_pkg::OP_ADD;
                        else if (r_bcnt < CAP) begin
                            b_op = spte_pkg::OP_INS;
                            n_bcnt = r_bcnt + 1'b1;
                        end else n_st = spte_pkg::ST_OVERFLOW;
                    end
                    spte_pkg::ACT_REM, spte_pkg::ACT_SCALE,
                    spte_pkg::ACT_ADD, spte_pkg::ACT_MUL: n_state = S_STREAM;
                    spte_pkg::ACT_READ: begin
                        if (r_acnt == '0) n_st = spte_pkg::ST_EMPTY;
                        else begin
                            n_state = S_READ;
                            n_lead  = a_terms[0].expon;
                        end
                    end
                    default: n_st = spte_pkg::ST_OK;
                endcase
            end
            S_STREAM: begin
                if (done_strm) begin
                    n_state = S_DRAIN;
                    n_drain = 2'(spte_pkg::MUL_LAT);
                end else begin
                    case (r_act)
                        spte_pkg::ACT_SCALE: begin
                            mul_iv = 1'b1;
                            a_op   = spte_pkg::OP_ROT;
                            n_i    = r_i + 1'b1;
                        end
                        spte_pkg::ACT_REM: begin
                            a_op = spte_pkg::OP_ROT;
                            n_i  = r_i + 1'b1;
                            if (a_terms[0].expon == r_expon) n_found = 1'b1;
                            else begin
                                w_op = spte_pkg::OP_APP;
                                n_n  = r_n + 1'b1;
                            end
                        end
                        spte_pkg::ACT_ADD: begin
                            if (!take_b) begin
                                a_op = spte_pkg::OP_ROT;
                                n_i  = r_i + 1'b1;
                            end
                            if (!take_a) begin
                                b_op = spte_pkg::OP_ROT;
                                n_j  = r_j + 1'b1;
                            end
                            if (take_b) begin
                                w_coef = b_terms[0].coef;
                                w_exp  = b_terms[0].expon;
                            end else if (!take_a) begin
                                w_coef = a_terms[0].coef + b_terms[0].coef;
                            end
                            if (r_n >= CAP) n_ovf = 1'b1;
                            else begin
                                w_op = spte_pkg::OP_APP;
                                n_n  = r_n + 1'b1;
                            end
                        end
                        default: begin
                            mul_iv = 1'b1;
                            mul_b  = b_terms[0].coef;
                            mul_ie = esum[15:0];
                            if (esum[16]) n_ovf = 1'b1;
                            b_op = spte_pkg::OP_ROT;
                            n_j  = r_j + 1'b1;
                            if (r_j + 1'b1 == r_bcnt) begin
                                a_op = spte_pkg::OP_ROT;
                                n_i  = r_i + 1'b1;
                                n_j  = '0;
                            end
                        end
                    endcase
                end
            end
            S_DRAIN: begin
                if (r_drain == 2'd0) n_state = S_DONE;
                else n_drain = r_drain - 1'b1;
            end
            S_DONE: begin
                n_state = S_OUT;
                case (r_act)
                    spte_pkg::ACT_SCALE: a_op = spte_pkg::OP_COPY;
                    spte_pkg::ACT_REM: begin
                        if (r_found) begin
                            a_op   = spte_pkg::OP_COPY;
                            n_acnt = r_acnt - 1'b1;
                        end else n_st = spte_pkg::ST_NOTFOUND;
                    end
                    default: begin
                        if (r_act == spte_pkg::ACT_MUL && (r_acnt == '0 || r_bcnt == '0))
                            n_acnt = '0;
                        else if (r_ovf) n_st = spte_pkg::ST_OVERFLOW;
                        else begin
                            a_op   = spte_pkg::OP_COPY;
                            n_acnt = r_n;
                        end
                    end
                endcase
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    n_mvalid = 1'b1; n_mlast = 1'b1; n_mst = r_st;
                    n_mcoef = '0; n_mexp = '0;
                    n_mcnt = r_acnt[5:0]; n_mlead = a_lead;
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_mvalid = 1'b1;
                    n_mlast  = (r_i + 1'b1 == r_acnt);
                    n_mst    = spte_pkg::ST_OK;
                    n_mcoef  = a_terms[0].coef;
                    n_mexp   = a_terms[0].expon;
                    n_mcnt   = r_acnt[5:0];
                    n_mlead  = r_lead;
                    a_op     = spte_pkg::OP_ROT;
                    n_i      = r_i + 1'b1;
                    if (r_i + 1'b1 == r_acnt) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        w_ctl = '{cnt: r_n, coef: w_coef, expon: w_exp};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_acnt   <= '0;
            r_bcnt   <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_acnt   <= n_acnt;
            r_bcnt   <= n_bcnt;
            r_mvalid <= n_mvalid;
        end
        if (r_state == S_IDLE && i_s_tvalid) begin
            r_act   <= i_s_tuser;
            r_coef  <= {{32{i_s_tdata[31]}}, i_s_tdata[31:0]};
            r_expon <= i_s_tdata[47:32];
        end
        r_n <= n_n; r_i <= n_i; r_j <= n_j; r_ovf <= n_ovf; r_found <= n_found;
        r_drain <= n_drain; r_st <= n_st; r_lead <= n_lead;
        r_mlast <= n_mlast; r_mst <= n_mst; r_mcoef <= n_mcoef; r_mexp <= n_mexp;
        r_mlead <= n_mlead; r_mcnt <= n_mcnt;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_mvalid;
    assign o_m_tdata  = {2'b00, r_mlead, r_mcnt, r_mexp, r_mcoef};
    assign o_m_tuser  = r_mst;
    assign o_m_tlast  = r_mlast;
endmodule
`default_nettype wire

[sim/tb.sv]
// Testbench for sparse_polynomial_term_engine: directed table, a capacity fill, then random actions.
// Predicts results with its own model of tables A and B; depends on spte_pkg and the RTL.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = spte_pkg::CAP_DEF;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] tcoef;
        logic [15:0] texp;
        logic        last;
        logic [5:0]  tcnt;
        logic [15:0] lead;
    } t_word;

    typedef struct {
        logic [3:0]  act;
        logic [31:0] coef;
        logic [15:0] expon;
        logic        chk;
        logic [1:0]  st;
        logic [5:0]  cnt;
    } t_stim;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [47:0]  i_s_tdata = '0;  // coef, expon
    logic [3:0]   i_s_tuser = '0;  // action
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [103:0] o_m_tdata;      // term_coef, term_expon, term_count, lead_expon
    logic [1:0]   o_m_tuser;      // status
    logic         o_m_tlast;

    sparse_polynomial_term_engine uut (.*);

    always #1 i_clk = ~i_clk;

    logic [63:0] a_c[CAP], b_c[CAP], w_c[CAP];
    logic [15:0] a_e[CAP], b_e[CAP], w_e[CAP];
    int a_n, b_n;
    t_word expected_words[$];
    int errors = 0;
    int cycles = 0;
    bit rx_idle_on = 1'b1;

    task automatic report(input string msg);
        $display("MISMATCH @%0d: %s", cycles, msg);
        errors++;
    endtask

    function automatic void queue_word(input t_word w);
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic logic [1:0] term_attach(ref logic [63:0] cs[CAP],
            ref logic [15:0] es[CAP], ref int n, input logic [63:0] c,
            input logic [15:0] e);
        int pos;
        for (int i = 0; i < n; i++)
            if (es[i] == e) begin
                cs[i] += c;
                return spte_pkg::ST_OK;
            end
        if (n >= CAP) return spte_pkg::ST_OVERFLOW;
        pos = 0;
        while (pos < n && es[pos] > e) pos++;
        for (int i = n; i > pos; i--) begin
            cs[i] = cs[i-1];
            es[i] = es[i-1];
        end
        cs[pos] = c;
        es[pos] = e;
        n++;
        return spte_pkg::ST_OK;
    endfunction

    function automatic t_word mk(input logic [1:0] st, input logic [63:0] c,
            input logic [15:0] e, input logic l);
        t_word w;
        w.status = st; w.tcoef = c; w.texp = e; w.last = l;
        w.tcnt = a_n[5:0];
        w.lead = a_n > 0 ? a_e[0] : 16'd0;
        return w;
    endfunction

    function automatic logic [1:0] sum_ab();
        int i = 0, j = 0, n = 0;
        while (i < a_n || j < b_n) begin
            if (n >= CAP) return spte_pkg::ST_OVERFLOW;
            if (j >= b_n || (i < a_n && a_e[i] > b_e[j])) begin
                w_c[n] = a_c[i]; w_e[n] = a_e[i]; i++;
            end else if (i >= a_n || a_e[i] < b_e[j]) begin
                w_c[n] = b_c[j]; w_e[n] = b_e[j]; j++;
            end else begin
                w_c[n] = a_c[i] + b_c[j]; w_e[n] = a_e[i]; i++; j++;
            end
            n++;
        end
        for (int k = 0; k < n; k++) begin
            a_c[k] = w_c[k]; a_e[k] = w_e[k];
        end
        a_n = n;
        return spte_pkg::ST_OK;
    endfunction

    function automatic logic [1:0] product_ab();
        int n = 0;
        logic [16:0] s;
        for (int i = 0; i < a_n; i++)
            for (int j = 0; j < b_n; j++) begin
                s = {1'b0, a_e[i]} + {1'b0, b_e[j]};
                if (s[16]) return spte_pkg::ST_OVERFLOW;
                if (term_attach(w_c, w_e, n, a_c[i] * b_c[j], s[15:0]) != spte_pkg::ST_OK)
                    return spte_pkg::ST_OVERFLOW;
            end
        for (int k = 0; k < n; k++) begin
            a_c[k] = w_c[k]; a_e[k] = w_e[k];
        end
        a_n = n;
        return spte_pkg::ST_OK;
    endfunction

    function automatic void predict_action(input logic [3:0] act, input logic [31:0] coef,
            input logic [15:0] e);
        logic [63:0] c = {{32{coef[31]}}, coef};
        logic [1:0] st = spte_pkg::ST_OK;
        int hit;
        case (act)
            spte_pkg::ACT_CLR_A: a_n = 0;
            spte_pkg::ACT_CLR_B: b_n = 0;
            spte_pkg::ACT_ATT_A: st = term_attach(a_c, a_e, a_n, c, e);
            spte_pkg::ACT_ATT_B: st = term_attach(b_c, b_e, b_n, c, e);
            spte_pkg::ACT_REM: begin
                hit = -1;
                for (int i = 0; i < a_n; i++) if (hit < 0 && a_e[i] == e) hit = i;
                if (hit < 0) st = spte_pkg::ST_NOTFOUND;
                else begin
                    for (int j = hit; j + 1 < a_n; j++) begin
                        a_c[j] = a_c[j+1]; a_e[j] = a_e[j+1];
                    end
                    a_n--;
                end
            end
            spte_pkg::ACT_SCALE: for (int i = 0; i < a_n; i++) a_c[i] *= c;
            spte_pkg::ACT_ADD: st = sum_ab();
            spte_pkg::ACT_MUL: st = product_ab();
            spte_pkg::ACT_READ: begin
                if (a_n == 0) queue_word(mk(spte_pkg::ST_EMPTY, '0, '0, 1'b1));
                for (int i = 0; i < a_n; i++)
                    queue_word(mk(spte_pkg::ST_OK, a_c[i], a_e[i], i + 1 == a_n));
                return;
            end
            default: ;
        endcase
        queue_word(mk(st, '0, '0, 1'b1));
    endfunction

    // output side: random stalls, compare against oldest expectation
    always @(posedge i_clk) begin
        t_word got, want;
        cycles <= cycles + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status = o_m_tuser;
            got.tcoef = o_m_tdata[63:0];
            got.texp = o_m_tdata[79:64];
            got.last = o_m_tlast;
            got.tcnt = o_m_tdata[85:80];
            got.lead = o_m_tdata[101:86];
            if (expected_words.size() == 0)
                report($sformatf("unexpected word %h", got));
            else begin
                want = expected_words.pop_front();
                if (got.status != want.status)
                    report($sformatf("status %0d want %0d", got.status, want.status));
                if (got.tcoef != want.tcoef)
                    report($sformatf("term_coef %h want %h", got.tcoef, want.tcoef));
                if (got.texp != want.texp)
                    report($sformatf("term_expon %h want %h", got.texp, want.texp));
                if (got.last != want.last)
                    report($sformatf("last %0d want %0d", got.last, want.last));
                if (got.tcnt != want.tcnt)
                    report($sformatf("term_count %0d want %0d", got.tcnt, want.tcnt));
                if (got.lead != want.lead)
                    report($sformatf("lead_expon %h want %h", got.lead, want.lead));
            end
        end
        if (cycles > 2000000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    int stall_left = 0;
    always @(negedge i_clk) begin
        if (!rx_idle_on || !i_rst_n) i_m_tready <= 1'b1;
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            i_m_tready <= 1'b0;
        end else i_m_tready <= 1'b1;
    end

    // leaves tvalid high at the negedge after the accept; the next call reloads or drops it, drain drops it
    task automatic send(input logic [3:0] act, input logic [31:0] coef,
            input logic [15:0] e, input bit idle);
        if (idle && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= act;
        i_s_tdata <= {e, coef};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_action(act, coef, e);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_exp();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 15));
            1: return 16'($urandom_range(32760, 32780));
            2: return 16'($urandom_range(65520, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    t_stim plan[$];

    initial begin
        a_n = 0;
        b_n = 0;
        // directed: chk rows carry a hand-typed status and term count
        plan = '{
            '{spte_pkg::ACT_READ,  32'd0,        16'd0,    1'b1, spte_pkg::ST_EMPTY,    6'd0},
            '{spte_pkg::ACT_REM,   32'd0,        16'd5,    1'b1, spte_pkg::ST_NOTFOUND, 6'd0},
            '{spte_pkg::ACT_MUL,   32'd0,        16'd0,    1'b1, spte_pkg::ST_OK,       6'd0},
            '{spte_pkg::ACT_ATT_A, 32'h7fffffff, 16'hffff, 1'b1, spte_pkg::ST_OK,       6'd1},
            '{spte_pkg::ACT_ATT_A, 32'h80000000, 16'd0,    1'b1, spte_pkg::ST_OK,       6'd2},
            '{spte_pkg::ACT_ATT_A, 32'hffffffff, 16'hffff, 1'b1, spte_pkg::ST_OK,       6'd2},
            '{spte_pkg::ACT_ATT_B, 32'd3,        16'd1,    1'b1, spte_pkg::ST_OK,       6'd2},
            '{spte_pkg::ACT_MUL,   32'd0,        16'd0,    1'b1, spte_pkg::ST_OVERFLOW, 6'd2},
            '{spte_pkg::ACT_READ,  32'd0,        16'd0,    1'b0, spte_pkg::ST_OK,       6'd0},
            '{spte_pkg::ACT_SCALE, 32'h80000000, 16'd0,    1'b0, spte_pkg::ST_OK,       6'd0},
            '{spte_pkg::ACT_ADD,   32'd0,        16'd0,    1'b0, spte_pkg::ST_OK,       6'd0},
            '{spte_pkg::ACT_REM,   32'd0,        16'hffff, 1'b0, spte_pkg::ST_OK,       6'd0},
            '{spte_pkg::ACT_REM,   32'd0,        16'd1,    1'b0, spte_pkg::ST_OK,       6'd0},
            '{spte_pkg::ACT_ATT_B, 32'h55555555, 16'h8000, 1'b0, spte_pkg::ST_OK,       6'd0},
            '{spte_pkg::ACT_MUL,   32'd0,        16'd0,    1'b0, spte_pkg::ST_OK,       6'd0},
            '{spte_pkg::ACT_READ,  32'd0,        16'd0,    1'b0, spte_pkg::ST_OK,       6'd0},
            '{4'd9,                32'd0,        16'd0,    1'b0, spte_pkg::ST_OK,       6'd0},
            '{4'd15,               32'haaaaaaaa, 16'haaaa, 1'b0, spte_pkg::ST_OK,       6'd0},
            '{spte_pkg::ACT_CLR_B, 32'd0,        16'd0,    1'b0, spte_pkg::ST_OK,       6'd0},
            '{spte_pkg::ACT_MUL,   32'd0,        16'd0,    1'b1, spte_pkg::ST_OK,       6'd0},
            '{spte_pkg::ACT_CLR_A, 32'd0,        16'd0,    1'b1, spte_pkg::ST_OK,       6'd0}
        };
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (plan[k]) begin
            send(plan[k].act, plan[k].coef, plan[k].expon, 1'b1);
            if (plan[k].chk && (expected_words[$].status != plan[k].st
                    || expected_words[$].tcnt != plan[k].cnt))
                report($sformatf("row %0d prediction off the table", k));
        end
        // fill A past capacity, then add into a full table
        for (int k = 0; k < CAP + 1; k++)
            send(spte_pkg::ACT_ATT_A, $urandom, 16'(k * 3), 1'b1);
        send(spte_pkg::ACT_ATT_B, 32'd1, 16'd1, 1'b1);
        send(spte_pkg::ACT_ADD, 32'd0, 16'd0, 1'b1);
        send(spte_pkg::ACT_READ, 32'd0, 16'd0, 1'b1);
        drain();
        // random sequences: build small A and B, then combine
        for (int r = 0; r < 19; r++) begin
            logic [3:0] act;
            if (r == 15) rx_idle_on = 1'b0;
            send(spte_pkg::ACT_CLR_A, 32'd0, 16'd0, rx_idle_on);
            send(spte_pkg::ACT_CLR_B, 32'd0, 16'd0, rx_idle_on);
            repeat ($urandom_range(0, 6))
                send(spte_pkg::ACT_ATT_A, $urandom, rand_exp(), rx_idle_on);
            repeat ($urandom_range(0, 5))
                send(spte_pkg::ACT_ATT_B, $urandom, rand_exp(), rx_idle_on);
            for (int q = 0; q < 3; q++) begin
                act = 4'($urandom_range(0, 15));
                if ($urandom_range(0, 1))
                    act = 4'($urandom_range(spte_pkg::ACT_REM, spte_pkg::ACT_MUL));
                send(act, $urandom, $urandom_range(0, 1) ? rand_exp() : a_e[0], rx_idle_on);
            end
            send(spte_pkg::ACT_READ, 32'd0, 16'd0, rx_idle_on);
        end
        drain();
        repeat (200) @(negedge i_clk);
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
